[hdl/keyframe_linear_player_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the keyframe linear player.
// Simulation builds get concurrent checks; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_PLAYER_ASSERT_SVH
`define KEYFRAME_LINEAR_PLAYER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define KFLP_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("keyframe player check failed");

// Next-cycle implication.
`define KFLP_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("keyframe player check failed");

`else

`define KFLP_ASSERT_IMP(label, clk, rst, pre, post)
`define KFLP_ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

[hdl/kflp_pkg.sv]
// ---------------------------------------------------------------------------
// kflp_pkg
// Shared constants and types of the keyframe linear player.
// ---------------------------------------------------------------------------
package kflp_pkg;

   // Store depth and derived widths.
   localparam int MAX_KEYFRAMES = 128;
   localparam int ADDR_W        = $clog2(MAX_KEYFRAMES);
   localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);

   // Fixed field widths.
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int STEP_W      = 8;
   localparam int SEG_OUT_W   = 7;
   localparam int FRAME_OUT_W = 8;

   // Divider: a 33-bit signed difference over an 8-bit step count.
   localparam int DIV_W     = DATA_W + 1;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 2);

   // Register file.
   localparam int CSR_DATA_W = 32;
   localparam int PADDR_W    = 3;
   localparam logic REG_STEPS_PER_SEGMENT = 1'b0;
   localparam logic [STEP_W-1:0] STEPS_RESET = 8'd90;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK   = 3'd0,
      MODE_SAVE   = 3'd1,
      MODE_APPEND = 3'd2,
      MODE_PLAY   = 3'd3,
      MODE_NUDGE  = 3'd4
   } mode_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] z;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] rot;
   } pose_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

[hdl/kflp_divider.sv]
// ---------------------------------------------------------------------------
// kflp_divider
// Bit-serial signed divider, one quotient bit per cycle, saturating to 32 bits.
// ---------------------------------------------------------------------------
module kflp_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [kflp_pkg::DIV_W-1:0]    dividend,
   input  logic        [kflp_pkg::STEP_W-1:0]   divisor,
   output logic signed [kflp_pkg::DATA_W-1:0]   quotient,
   output kflp_pkg::div_status_type             status
);
   import kflp_pkg::*;

   localparam logic [DIV_CNT_W-1:0] CNT_PREP = DIV_CNT_W'(DIV_STEPS + 1);
   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(1);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;
   logic [STEP_W:0]      trial;
   logic                 fits;

   // One restoring step: shift the next dividend bit into the remainder.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         neg_in = dividend[DIV_W-1];
         rem_in = '0;
         cnt_in = CNT_PREP;
      end else if (cnt_ff == CNT_PREP) begin
         // Take the magnitude before the shift-subtract steps.
         quo_in = neg_ff ? (~quo_ff + DIV_W'(1)) : quo_ff;
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? STEP_W'(trial - {1'b0, divisor}) : STEP_W'(trial);
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == CNT_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // Restore the sign and clamp to the signed 32-bit range.
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > DIV_W'(33'h0_8000_0000)) begin
            quotient = 32'sh8000_0000;
         end else begin
            quotient = DATA_W'(~quo_ff + DIV_W'(1));
         end
      end else begin
         if (quo_ff[DIV_W-1] || quo_ff[DIV_W-2]) begin
            quotient = 32'sh7FFF_FFFF;
         end else begin
            quotient = DATA_W'(quo_ff);
         end
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

[hdl/keyframe_linear_player.sv]
// ---------------------------------------------------------------------------
// keyframe_linear_player
// Simple items pass through ST_REPLY to the result register; a play or a segment
// change first reads two keyframes and runs the 33-step serial dividers. One item at
// a time: the next item is taken once the result is registered and the block is back
// in ST_IDLE; a stalled result holds the block in ST_REPLY.
// Reset (synchronous, active high) empties the store, zeroes pose and counters and
// sets 90 steps per segment.
// ---------------------------------------------------------------------------
module keyframe_linear_player (
   input  logic                                  clock,
   input  logic                                  reset,

   // Input channel.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic        [kflp_pkg::MODE_W-1:0]    req_mode,
   input  logic signed [kflp_pkg::DATA_W-1:0]    req_val_z,
   input  logic signed [kflp_pkg::DATA_W-1:0]    req_val_y,
   input  logic signed [kflp_pkg::DATA_W-1:0]    req_val_rot,

   // Result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [kflp_pkg::DATA_W-1:0]    rsp_pose_z,
   output logic signed [kflp_pkg::DATA_W-1:0]    rsp_pose_y,
   output logic signed [kflp_pkg::DATA_W-1:0]    rsp_pose_rot,
   output logic                                  rsp_playing,
   output logic        [kflp_pkg::SEG_OUT_W-1:0] rsp_segment,
   output logic        [kflp_pkg::STEP_W-1:0]    rsp_step_count,
   output logic        [kflp_pkg::FRAME_OUT_W-1:0] rsp_frame_count,
   output logic                                  rsp_rejected,

   // Configuration port.
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [kflp_pkg::PADDR_W-1:0]   paddr,
   input  logic        [kflp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [kflp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import kflp_pkg::*;

   // The sequencer. Simple items finish in the accept cycle and wait in
   // ST_REPLY for the result register. A play or a segment change reads the
   // start keyframe (ST_READ_B issues the end keyframe), starts the dividers
   // in ST_LOAD and waits for them in ST_DIVIDE.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ_B = 5'b00010,
      ST_LOAD   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   localparam int SEG_EXT_W = CNT_W + 1;

   state_type           state_ff, state_in;
   pose_type            cur_ff, cur_in;
   pose_type            inc_ff, inc_in;
   pose_type            from_ff, from_in;
   logic                run_ff, run_in;
   logic [ADDR_W-1:0]   seg_ff, seg_in;
   logic [STEP_W-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]    frames_ff, frames_in;
   logic                rej_ff, rej_in;
   logic                load_pose_ff, load_pose_in;
   logic [STEP_W-1:0]   steps_ff;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   pose_type            rsp_pose_ff;
   logic                rsp_playing_ff;
   logic [ADDR_W-1:0]   rsp_seg_ff;
   logic [STEP_W-1:0]   rsp_tick_ff;
   logic [CNT_W-1:0]    rsp_frames_ff;
   logic                rsp_rej_ff;
   logic                rsp_load;

   // Keyframe store: one synchronous memory holding all three channels.
   pose_type            store_mem [MAX_KEYFRAMES];
   pose_type            rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;
   pose_type            mem_wdata;

   // Divider lanes.
   logic                     div_start;
   logic signed [DIV_W-1:0]  diff_z, diff_y, diff_rot;
   logic signed [DATA_W-1:0] quo_z, quo_y, quo_rot;
   div_status_type           div_st_z, div_st_y, div_st_rot;
   logic                     div_done;

   logic                   accept;
   logic [STEP_W-1:0]      eff_steps;
   logic [ADDR_W-1:0]      seg_next;
   logic [SEG_EXT_W-1:0]   seg_next_p2;
   logic [SEG_EXT_W-1:0]   frames_ext;
   logic                   store_full;
   logic                   csr_write;

   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return s[DATA_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration. The only register is the step count per segment;
   // a value of zero is treated as one.
   // ------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[PADDR_W-1] == REG_STEPS_PER_SEGMENT) ?
                      CSR_DATA_W'(steps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
      end else if (csr_write && paddr[PADDR_W-1] == REG_STEPS_PER_SEGMENT) begin
         steps_ff <= pwdata[STEP_W-1:0];
      end
   end

   assign eff_steps = (steps_ff == '0) ? STEP_W'(1) : steps_ff;

   // ------------------------------------------------------------------
   // Control.
   // ------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign seg_next    = seg_ff + ADDR_W'(1);
   assign seg_next_p2 = SEG_EXT_W'(seg_next) + SEG_EXT_W'(2);
   assign frames_ext  = SEG_EXT_W'(frames_ff);
   assign store_full  = (frames_ff >= CNT_W'(MAX_KEYFRAMES));
   assign div_done    = div_st_z.done && div_st_y.done && div_st_rot.done;

   // The differences are formed from the registered read data of the end
   // keyframe and the start keyframe captured in from_ff in ST_READ_B.
   assign diff_z   = {rd_data_ff.z[DATA_W-1], rd_data_ff.z} -
                     {from_ff.z[DATA_W-1], from_ff.z};
   assign diff_y   = {rd_data_ff.y[DATA_W-1], rd_data_ff.y} -
                     {from_ff.y[DATA_W-1], from_ff.y};
   assign diff_rot = {rd_data_ff.rot[DATA_W-1], rd_data_ff.rot} -
                     {from_ff.rot[DATA_W-1], from_ff.rot};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      inc_in       = inc_ff;
      from_in      = from_ff;
      run_in       = run_ff;
      seg_in       = seg_ff;
      tick_in      = tick_ff;
      frames_in    = frames_ff;
      rej_in       = rej_ff;
      load_pose_in = load_pose_ff;
      rd_addr      = seg_next;
      mem_we       = 1'b0;
      mem_wdata    = cur_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rej_in       = 1'b0;
               load_pose_in = 1'b0;
               state_in     = ST_REPLY;
               case (req_mode)
                  MODE_TICK: begin
                     if (run_ff) begin
                        if (tick_ff >= eff_steps) begin
                           // The segment is used up: move on, or end playback
                           // when no further keyframe follows.
                           seg_in = seg_next;
                           if (seg_next_p2 > frames_ext) begin
                              seg_in = '0;
                              run_in = 1'b0;
                           end else begin
                              tick_in  = '0;
                              state_in = ST_READ_B;
                           end
                        end else begin
                           cur_in.z   = sat_add(cur_ff.z, inc_ff.z);
                           cur_in.y   = sat_add(cur_ff.y, inc_ff.y);
                           cur_in.rot = sat_add(cur_ff.rot, inc_ff.rot);
                           tick_in    = tick_ff + STEP_W'(1);
                        end
                     end
                  end
                  MODE_SAVE, MODE_APPEND: begin
                     if (store_full) begin
                        rej_in = 1'b1;
                     end else begin
                        mem_we = 1'b1;
                        if (req_mode == MODE_APPEND) begin
                           mem_wdata = '{z: req_val_z, y: req_val_y, rot: req_val_rot};
                        end
                        frames_in = frames_ff + CNT_W'(1);
                     end
                  end
                  MODE_PLAY: begin
                     if (run_ff) begin
                        run_in = 1'b0;
                     end else if (frames_ff > CNT_W'(1)) begin
                        seg_in       = '0;
                        tick_in      = '0;
                        run_in       = 1'b1;
                        load_pose_in = 1'b1;
                        rd_addr      = '0;
                        state_in     = ST_READ_B;
                     end
                  end
                  MODE_NUDGE: begin
                     cur_in.z   = sat_add(cur_ff.z, req_val_z);
                     cur_in.y   = sat_add(cur_ff.y, req_val_y);
                     cur_in.rot = sat_add(cur_ff.rot, req_val_rot);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ_B: begin
            // Start keyframe is on the read port; issue the end keyframe.
            rd_addr = seg_ff + ADDR_W'(1);
            from_in = rd_data_ff;
            if (load_pose_ff) begin
               cur_in = rd_data_ff;
            end
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               inc_in   = '{z: quo_z, y: quo_y, rot: quo_rot};
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_ff       <= '0;
         inc_ff       <= '0;
         run_ff       <= 1'b0;
         seg_ff       <= '0;
         tick_ff      <= '0;
         frames_ff    <= '0;
         rej_ff       <= 1'b0;
         load_pose_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         inc_ff       <= inc_in;
         run_ff       <= run_in;
         seg_ff       <= seg_in;
         tick_ff      <= tick_in;
         frames_ff    <= frames_in;
         rej_ff       <= rej_in;
         load_pose_ff <= load_pose_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      from_ff <= from_in;
   end

   // Result payload, taken from the architectural state once it is final.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pose_ff    <= cur_ff;
         rsp_playing_ff <= run_ff;
         rsp_seg_ff     <= seg_ff;
         rsp_tick_ff    <= tick_ff;
         rsp_frames_ff  <= frames_ff;
         rsp_rej_ff     <= rej_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pose_z      = rsp_pose_ff.z;
   assign rsp_pose_y      = rsp_pose_ff.y;
   assign rsp_pose_rot    = rsp_pose_ff.rot;
   assign rsp_playing     = rsp_playing_ff;
   assign rsp_segment     = SEG_OUT_W'(rsp_seg_ff);
   assign rsp_step_count  = rsp_tick_ff;
   assign rsp_frame_count = FRAME_OUT_W'(rsp_frames_ff);
   assign rsp_rejected    = rsp_rej_ff;

   // ------------------------------------------------------------------
   // Keyframe store. Writes happen only when an item is accepted and reads
   // are only consumed in the states that follow, so a read never overlaps
   // a write to the same entry and no forwarding is needed.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[frames_ff[ADDR_W-1:0]] <= mem_wdata;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Three divider lanes run side by side, one per channel.
   // ------------------------------------------------------------------
   kflp_divider u_div_z (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_z),
      .divisor  (eff_steps),
      .quotient (quo_z),
      .status   (div_st_z)
   );

   kflp_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_y),
      .divisor  (eff_steps),
      .quotient (quo_y),
      .status   (div_st_y)
   );

   kflp_divider u_div_rot (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_rot),
      .divisor  (eff_steps),
      .quotient (quo_rot),
      .status   (div_st_rot)
   );

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
`include "keyframe_linear_player_assert.svh"

   // While playing, the current segment always has an end keyframe.
   `KFLP_ASSERT_IMP(a_seg_in_store, clock, reset, run_ff, (SEG_EXT_W'(seg_ff) + SEG_EXT_W'(2)) <= frames_ext)

   // A store write grows the fill count by exactly one.
   `KFLP_ASSERT_NXT(a_fill_count, clock, reset, mem_we, frames_ff == $past(frames_ff) + CNT_W'(1))

   // While waiting on the dividers, the z lane is running or all lanes are just done.
   `KFLP_ASSERT_IMP(a_div_alive, clock, reset, state_ff == ST_DIVIDE, div_st_z.busy || div_done)

   // A finished item reaches the result register and the block goes idle.
   `KFLP_ASSERT_NXT(a_reply, clock, reset, state_ff == ST_REPLY && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == ST_IDLE)

endmodule
